[sv/sawm_pkg.sv]
// ----------------------------------------------------------------------------
// Steer angle wheel mixer package
// Shared widths, command codes and angle limits for the wheel mixer.
// ----------------------------------------------------------------------------
package sawm_pkg;

    localparam int CODE_BITS      = 8;
    localparam int ANGLE_BITS     = 9;
    localparam int RAMP_BITS      = 7;
    localparam int DUTY_BITS_DEF  = 8;
    localparam int MIN_DUTY_RESET = 50;

    localparam logic [CODE_BITS-1:0] CODE_STOP    = 8'd48;
    localparam logic [CODE_BITS-1:0] CODE_FORWARD = 8'd49;

    localparam int QUARTER_DEG = 90;

    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER       = 9'd90;
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF          = 9'd180;
    localparam logic [ANGLE_BITS-1:0] ANGLE_THREE_QUARTER = 9'd270;
    localparam logic [ANGLE_BITS-1:0] ANGLE_FULL          = 9'd360;

endpackage

[sv/sawm_if.sv]
// ----------------------------------------------------------------------------
// Wheel mixer channel interfaces
// Valid/ready channels for drive commands and for wheel drive results.
// ----------------------------------------------------------------------------
interface sawm_cmd_if #(
    parameter int DUTY_BITS = 8
);
    import sawm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CODE_BITS-1:0]  direction_code;
    logic [DUTY_BITS-1:0]  speed_duty;
    logic [ANGLE_BITS-1:0] steer_angle;

    modport source (output valid, direction_code, speed_duty, steer_angle, input ready);
    modport sink   (input valid, direction_code, speed_duty, steer_angle, output ready);
endinterface

interface sawm_drive_if #(
    parameter int DUTY_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] left_duty;
    logic                 left_reverse;
    logic [DUTY_BITS-1:0] right_duty;
    logic                 right_reverse;

    modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
                    input ready);
    modport sink   (input valid, left_duty, left_reverse, right_duty, right_reverse,
                    output ready);
endinterface

[sv/sawm_ramp.sv]
// ----------------------------------------------------------------------------
// Wheel mixer ramp datapath
// Two register stages: the ramp offset times the duty span, then an exact
// division by ninety through a reciprocal multiply.
// ----------------------------------------------------------------------------
module sawm_ramp #(
    parameter int DUTY_BITS = sawm_pkg::DUTY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           en_mul,
    input  logic                           en_div,
    input  logic [sawm_pkg::RAMP_BITS-1:0] x,
    input  logic [DUTY_BITS-1:0]           floor_duty,
    input  logic [DUTY_BITS-1:0]           full_duty,
    output logic [DUTY_BITS-1:0]           quot
);
    import sawm_pkg::*;

    localparam int PROD_BITS  = DUTY_BITS + RAMP_BITS;
    localparam int SHIFT      = PROD_BITS + RAMP_BITS;
    localparam int RECIP_BITS = SHIFT - 6;
    localparam int WIDE_BITS  = PROD_BITS + RECIP_BITS;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(QUARTER_DEG - 1)) / 64'(QUARTER_DEG);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_L);

    logic [DUTY_BITS-1:0] span;
    logic [PROD_BITS-1:0] prod_next;
    logic [PROD_BITS-1:0] prod_reg;
    logic [WIDE_BITS-1:0] wide;
    logic [DUTY_BITS-1:0] quot_reg;

    assign span      = full_duty - floor_duty;
    assign prod_next = PROD_BITS'(x) * PROD_BITS'(span);
    assign wide      = WIDE_BITS'(prod_reg) * WIDE_BITS'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            prod_reg <= prod_next;
        end
        if (en_div)
        begin
            quot_reg <= wide[SHIFT +: DUTY_BITS];
        end
    end

    assign quot = quot_reg;

endmodule

[sv/steer_angle_wheel_mixer_unit.sv]
// ----------------------------------------------------------------------------
// Steer angle wheel mixer
// Turns a drive command into duty and direction for the left and right
// wheel pairs of a differential-drive car.
//
//   Channel    Role     Handshake    Content
//   cmd        sink     valid/ready  direction_code, speed_duty, steer_angle
//   drive      source   valid/ready  left/right duty and reverse flag
//   cfg_*      write    enable only  min_duty
//
// The pipeline has four stages (decode, span multiply, reciprocal divide,
// output mix) and accepts one command per cycle while it is not stalled.
// Each stage holds when the stage after it is full and stalled; a full output
// register does not block the stages behind it while they have room. Reset
// clears the valid bits and sets min_duty to 50. Commands with an invalid
// angle leave no result unless they are stop commands.
// ----------------------------------------------------------------------------
module steer_angle_wheel_mixer_unit #(
    parameter int DUTY_BITS = sawm_pkg::DUTY_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [DUTY_BITS-1:0] cfg_wdata,
    sawm_cmd_if.sink             cmd,
    sawm_drive_if.source         drive
);
    import sawm_pkg::*;

    typedef struct packed {
        logic                 stop;
        logic                 ramp_left;
        logic                 left_rev;
        logic                 right_rev;
        logic [DUTY_BITS-1:0] lo;
        logic [DUTY_BITS-1:0] full;
    } side_t;

    logic [DUTY_BITS-1:0] min_duty_reg;

    logic [DUTY_BITS-1:0]  lo;
    logic [DUTY_BITS-1:0]  full;
    logic [ANGLE_BITS-1:0] ang;
    logic                  stop;
    logic                  fwd;
    logic                  keep;
    logic                  q1;
    logic                  q2;
    logic                  q3;
    logic [ANGLE_BITS-1:0] x_wide;
    side_t                 side_next;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    side_t                side1_reg;
    side_t                side2_reg;
    side_t                side3_reg;
    logic [RAMP_BITS-1:0] x1_reg;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdy4;
    logic [DUTY_BITS-1:0] quot;
    logic [DUTY_BITS-1:0] ramp;

    logic [DUTY_BITS-1:0] left_duty_reg;
    logic [DUTY_BITS-1:0] left_duty_next;
    logic [DUTY_BITS-1:0] right_duty_reg;
    logic [DUTY_BITS-1:0] right_duty_next;
    logic                 left_rev_reg;
    logic                 right_rev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg <= DUTY_BITS'(MIN_DUTY_RESET);
        end
        else if (cfg_we)
        begin
            min_duty_reg <= cfg_wdata;
        end
    end

    assign rdy4      = !v4_reg || drive.ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign cmd.ready = rdy1;

    // Decode: speed floor, quadrant, ramp offset and directions.
    always_comb
    begin
        lo   = min_duty_reg;
        full = (cmd.speed_duty < lo) ? lo : cmd.speed_duty;
        ang  = cmd.steer_angle;
        stop = (cmd.direction_code == CODE_STOP);
        fwd  = (cmd.direction_code == CODE_FORWARD);
        keep = stop || ((ang != '0) && (ang <= ANGLE_FULL));
        q1   = (ang <= ANGLE_QUARTER);
        q2   = !q1 && (ang <= ANGLE_HALF);
        q3   = !q1 && !q2 && (ang <= ANGLE_THREE_QUARTER);

        side_next.stop = stop;
        side_next.lo   = lo;
        side_next.full = full;
        if (q1)
        begin
            x_wide              = ang;
            side_next.ramp_left = 1'b0;
            side_next.left_rev  = !fwd;
            side_next.right_rev = 1'b1;
        end
        else if (q2)
        begin
            x_wide              = ANGLE_HALF - ang;
            side_next.ramp_left = 1'b1;
            side_next.left_rev  = 1'b1;
            side_next.right_rev = !fwd;
        end
        else if (q3)
        begin
            x_wide              = fwd ? (ang - ANGLE_HALF) : (ANGLE_THREE_QUARTER - ang);
            side_next.ramp_left = 1'b1;
            side_next.left_rev  = 1'b0;
            side_next.right_rev = !fwd;
        end
        else
        begin
            x_wide              = ANGLE_FULL - ang;
            side_next.ramp_left = 1'b0;
            side_next.left_rev  = !fwd;
            side_next.right_rev = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= cmd.valid && keep;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            side1_reg <= side_next;
            x1_reg    <= x_wide[RAMP_BITS-1:0];
        end
        if (rdy2)
        begin
            side2_reg <= side1_reg;
        end
        if (rdy3)
        begin
            side3_reg <= side2_reg;
        end
        if (rdy4)
        begin
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            left_rev_reg   <= side3_reg.left_rev && !side3_reg.stop;
            right_rev_reg  <= side3_reg.right_rev && !side3_reg.stop;
        end
    end

    sawm_ramp #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ramp (
        .clk        (clk),
        .en_mul     (rdy2),
        .en_div     (rdy3),
        .x          (x1_reg),
        .floor_duty (side1_reg.lo),
        .full_duty  (side1_reg.full),
        .quot       (quot)
    );

    always_comb
    begin
        ramp = side3_reg.lo + quot;
        if (side3_reg.stop)
        begin
            left_duty_next  = '0;
            right_duty_next = '0;
        end
        else if (side3_reg.ramp_left)
        begin
            left_duty_next  = ramp;
            right_duty_next = side3_reg.full;
        end
        else
        begin
            left_duty_next  = side3_reg.full;
            right_duty_next = ramp;
        end
    end

    assign drive.valid         = v4_reg;
    assign drive.left_duty     = left_duty_reg;
    assign drive.left_reverse  = left_rev_reg;
    assign drive.right_duty    = right_duty_reg;
    assign drive.right_reverse = right_rev_reg;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Steer angle wheel mixer testbench
// Sends drive commands through the valid/ready command channel and checks
// every wheel drive result, in order, against a behavioral mixer or a
// fixed table result; the table covers stop, forward and reverse commands,
// angle limits and the reverse half-turn jump. Random phases follow, each
// with its own min_duty setting, most with bursty idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sawm_pkg::*;

    localparam int DUTY_W      = DUTY_BITS_DEF;
    localparam int LATENCY     = 4;
    localparam int STALL_LIMIT = 500;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int TABLE_ROWS  = 23;

    localparam logic [CODE_BITS-1:0] CODE_REVERSE   = 8'h52;
    localparam logic [CODE_BITS-1:0] CODE_NUL       = 8'h00;
    localparam logic [CODE_BITS-1:0] CODE_ALL_ONES  = 8'hFF;
    localparam logic [CODE_BITS-1:0] CODE_DIGIT_TWO = 8'h32;

    typedef logic [DUTY_W-1:0]     duty_t;
    typedef logic [ANGLE_BITS-1:0] angle_t;
    typedef logic [CODE_BITS-1:0]  code_t;

    typedef struct packed {
        duty_t left_duty;
        logic  left_reverse;
        duty_t right_duty;
        logic  right_reverse;
    } wheel_drive_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_RESULT, ROW_SILENT} row_kind_t;

    typedef struct packed {
        code_t        code;
        duty_t        speed;
        angle_t       angle;
        row_kind_t    kind;
        wheel_drive_t fixed;
    } drive_cmd_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    duty_t        cfg_wdata;
    row_kind_t    shown_kind;
    wheel_drive_t shown_fixed;

    wheel_drive_t drive_q[$];
    duty_t        floor_duty;
    int           errors;
    int           stall_cycles;
    int           ready_left;
    bit           calm;

    sawm_cmd_if   #(.DUTY_BITS(DUTY_W)) cmd_ch ();
    sawm_drive_if #(.DUTY_BITS(DUTY_W)) drive_ch ();

    steer_angle_wheel_mixer_unit #(
        .DUTY_BITS(DUTY_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd_ch),
        .drive    (drive_ch)
    );

    always #5 clk = ~clk;

    function automatic duty_t ramp_duty(int x, int lo, int s);
        return duty_t'(lo + (x * (s - lo)) / QUARTER_DEG);
    endfunction

    function automatic bit mix_drive(code_t code, duty_t speed, angle_t angle,
                                     duty_t lo_duty, output wheel_drive_t res);
        int lo;
        int s;
        int a;
        bit fwd;
        lo  = lo_duty;
        s   = (speed < lo_duty) ? lo_duty : speed;
        a   = angle;
        res = '0;
        if (code == CODE_STOP)
        begin
            return 1'b1;
        end
        if (a == 0 || a > ANGLE_FULL)
        begin
            return 1'b0;
        end
        fwd = (code == CODE_FORWARD);
        if (a <= ANGLE_QUARTER)
        begin
            res.left_duty     = duty_t'(s);
            res.left_reverse  = !fwd;
            res.right_duty    = ramp_duty(a, lo, s);
            res.right_reverse = 1'b1;
        end
        else if (a <= ANGLE_HALF)
        begin
            res.left_duty     = ramp_duty(int'(ANGLE_HALF) - a, lo, s);
            res.left_reverse  = 1'b1;
            res.right_duty    = duty_t'(s);
            res.right_reverse = !fwd;
        end
        else if (a <= ANGLE_THREE_QUARTER)
        begin
            res.left_duty     = fwd ? ramp_duty(a - int'(ANGLE_HALF), lo, s)
                                    : ramp_duty(int'(ANGLE_THREE_QUARTER) - a, lo, s);
            res.left_reverse  = 1'b0;
            res.right_duty    = duty_t'(s);
            res.right_reverse = !fwd;
        end
        else
        begin
            res.left_duty     = duty_t'(s);
            res.left_reverse  = !fwd;
            res.right_duty    = ramp_duty(int'(ANGLE_FULL) - a, lo, s);
            res.right_reverse = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic drive_cmd_t random_command();
        drive_cmd_t c;
        int         pick;
        c      = '0;
        c.kind = ROW_PREDICT;
        pick   = $urandom_range(0, 99);
        if (pick < 15)
            c.code = CODE_STOP;
        else if (pick < 55)
            c.code = CODE_FORWARD;
        else if (pick < 70)
            c.code = CODE_REVERSE;
        else
            c.code = code_t'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            c.speed = '0;
        else if (pick < 20)
            c.speed = '1;
        else
            c.speed = duty_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c.angle = '0;
        else if (pick < 16)
            c.angle = angle_t'($urandom_range(int'(ANGLE_FULL) + 1, 511));
        else if (pick < 30)
        begin
            case ($urandom_range(0, 7))
                0:       c.angle = 9'd1;
                1:       c.angle = ANGLE_QUARTER;
                2:       c.angle = ANGLE_QUARTER + 9'd1;
                3:       c.angle = ANGLE_HALF;
                4:       c.angle = ANGLE_HALF + 9'd1;
                5:       c.angle = ANGLE_THREE_QUARTER;
                6:       c.angle = ANGLE_THREE_QUARTER + 9'd1;
                default: c.angle = ANGLE_FULL;
            endcase
        end
        else
            c.angle = angle_t'($urandom_range(1, int'(ANGLE_FULL)));
        return c;
    endfunction

    task automatic send_command(drive_cmd_t c);
        @(negedge clk);
        cmd_ch.valid          <= 1'b1;
        cmd_ch.direction_code <= c.code;
        cmd_ch.speed_duty     <= c.speed;
        cmd_ch.steer_angle    <= c.angle;
        shown_kind            <= c.kind;
        shown_fixed           <= c.fixed;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic hold_commands(int n);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (drive_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_floor(duty_t v);
        wait_results_drained();
        repeat (LATENCY + 2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_left == 0)
            begin
                if (calm)
                begin
                    drive_ch.ready <= 1'b1;
                    ready_left = 1;
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    drive_ch.ready <= 1'b0;
                    ready_left = $urandom_range(1, 15);
                end
                else
                begin
                    drive_ch.ready <= 1'b1;
                    ready_left = $urandom_range(1, 30);
                end
            end
            ready_left = ready_left - 1;
        end
    end

    always @(posedge clk)
    begin : check_block
        wheel_drive_t got;
        wheel_drive_t want;
        wheel_drive_t predicted;
        if (rst_n)
        begin
            if (drive_ch.valid && drive_ch.ready)
            begin
                got = '{drive_ch.left_duty, drive_ch.left_reverse,
                        drive_ch.right_duty, drive_ch.right_reverse};
                if (drive_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected none, actual L%0d/%0b R%0d/%0b",
                             $time, got.left_duty, got.left_reverse,
                             got.right_duty, got.right_reverse);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.left_duty !== want.left_duty
                        || got.left_reverse !== want.left_reverse
                        || got.right_duty !== want.right_duty
                        || got.right_reverse !== want.right_reverse)
                    begin
                        errors++;
                        $display("%0t: expected L%0d/%0b R%0d/%0b, actual L%0d/%0b R%0d/%0b",
                                 $time, want.left_duty, want.left_reverse,
                                 want.right_duty, want.right_reverse,
                                 got.left_duty, got.left_reverse,
                                 got.right_duty, got.right_reverse);
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                if (shown_kind == ROW_RESULT)
                    drive_q.push_back(shown_fixed);
                else if (shown_kind == ROW_PREDICT
                         && mix_drive(cmd_ch.direction_code, cmd_ch.speed_duty,
                                      cmd_ch.steer_angle, floor_duty, predicted))
                    drive_q.push_back(predicted);
            end
            if (cfg_we)
                floor_duty = cfg_wdata;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (drive_ch.valid && drive_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results still expected",
                     $time, stall_cycles, drive_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        drive_cmd_t directed [TABLE_ROWS];
        duty_t      floor_plan [PHASES];
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.direction_code = '0;
        cmd_ch.speed_duty     = '0;
        cmd_ch.steer_angle    = '0;
        drive_ch.ready        = 1'b0;
        shown_kind            = ROW_PREDICT;
        shown_fixed           = '0;
        floor_duty            = duty_t'(MIN_DUTY_RESET);
        errors                = 0;
        stall_cycles          = 0;
        ready_left            = 0;
        calm                  = 1'b0;

        directed = '{
            '{CODE_STOP,      8'd255, 9'd0,   ROW_RESULT,  '{8'd0,   1'b0, 8'd0,   1'b0}},
            '{CODE_STOP,      8'd0,   9'd511, ROW_RESULT,  '{8'd0,   1'b0, 8'd0,   1'b0}},
            '{CODE_STOP,      8'd128, 9'd45,  ROW_RESULT,  '{8'd0,   1'b0, 8'd0,   1'b0}},
            '{CODE_FORWARD,   8'd255, 9'd0,   ROW_SILENT,  '0},
            '{CODE_FORWARD,   8'd255, 9'd361, ROW_SILENT,  '0},
            '{CODE_REVERSE,   8'd0,   9'd511, ROW_SILENT,  '0},
            '{CODE_FORWARD,   8'd0,   9'd90,  ROW_RESULT,  '{8'd50,  1'b0, 8'd50,  1'b1}},
            '{CODE_FORWARD,   8'd255, 9'd90,  ROW_RESULT,  '{8'd255, 1'b0, 8'd255, 1'b1}},
            '{CODE_FORWARD,   8'd255, 9'd180, ROW_RESULT,  '{8'd50,  1'b1, 8'd255, 1'b0}},
            '{CODE_FORWARD,   8'd255, 9'd360, ROW_RESULT,  '{8'd255, 1'b0, 8'd50,  1'b0}},
            '{CODE_REVERSE,   8'd255, 9'd180, ROW_RESULT,  '{8'd50,  1'b1, 8'd255, 1'b1}},
            '{CODE_REVERSE,   8'd255, 9'd360, ROW_RESULT,  '{8'd255, 1'b1, 8'd50,  1'b0}},
            '{CODE_REVERSE,   8'd255, 9'd181, ROW_PREDICT, '0},
            '{CODE_FORWARD,   8'd200, 9'd1,   ROW_PREDICT, '0},
            '{CODE_FORWARD,   8'd200, 9'd91,  ROW_PREDICT, '0},
            '{CODE_FORWARD,   8'd200, 9'd181, ROW_PREDICT, '0},
            '{CODE_FORWARD,   8'd200, 9'd270, ROW_PREDICT, '0},
            '{CODE_FORWARD,   8'd200, 9'd271, ROW_PREDICT, '0},
            '{CODE_REVERSE,   8'd100, 9'd1,   ROW_PREDICT, '0},
            '{CODE_NUL,       8'd100, 9'd91,  ROW_PREDICT, '0},
            '{CODE_ALL_ONES,  8'd100, 9'd270, ROW_PREDICT, '0},
            '{CODE_DIGIT_TWO, 8'd30,  9'd271, ROW_PREDICT, '0},
            '{CODE_FORWARD,   8'd50,  9'd45,  ROW_PREDICT, '0}
        };
        floor_plan = '{8'd0, 8'd255, 8'd1, 8'd254, duty_t'($urandom), 8'd50,
                       duty_t'($urandom), duty_t'($urandom)};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if ($urandom_range(0, 3) == 0)
                hold_commands($urandom_range(1, 15));
            send_command(directed[i]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_floor(floor_plan[p]);
            calm = (p == 3 || p == PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && p % 2 == 0)
                    wait_results_drained();
                if (!calm && $urandom_range(0, 99) < 20)
                    hold_commands($urandom_range(1, 15));
                send_command(random_command());
            end
        end

        wait_results_drained();
        repeat (LATENCY + 4) @(negedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[files.f]
sv/sawm_pkg.sv
sv/sawm_if.sv
sv/sawm_ramp.sv
sv/steer_angle_wheel_mixer_unit.sv
tb/tb_top.sv
